// File: design/lap_pkg.sv
package lap_pkg;

    localparam int CMD_W        = 4;
    localparam int FRAME_W      = 48;
    localparam int DUR_W        = 16;
    localparam int POS_IN_W     = 8;
    localparam int REP_W        = 8;
    localparam int MASK_W       = 16;
    localparam int TICK_W       = 16;
    localparam int PHASE_W      = 6;
    localparam int LEVEL_BITS   = 3;
    localparam int MAX_LIGHTS   = 16;
    localparam int ENTRY_W      = DUR_W + FRAME_W;
    localparam int TARGET_LSB   = 32;
    localparam int POS_SRC_W    = 16;
    localparam int MOD_STEPS    = 2;
    localparam int MOD_CNT_W    = $clog2(MOD_STEPS);
    localparam int PWM_MOD      = 49;

    localparam int FRAME_DEPTH_DEF = 256;
    localparam int LIGHT_COUNT_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_SETFRAME   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_GETFRAME   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SETPOS     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_GETPOS     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_WRITEFRAME = 4'd4;
    localparam logic [CMD_W-1:0] CMD_START      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_PAUSE      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_RESET      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ANIMTICK   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_PWMTICK    = 4'd9;

    localparam logic [PHASE_W-1:0] LEVEL_SQ [0:7] = '{
        6'd0, 6'd1, 6'd4, 6'd9, 6'd16, 6'd25, 6'd36, 6'd49
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NEXT,
        S_MOD,
        S_LAND,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DIRECT,
        OP_TICK,
        OP_NEXT,
        OP_MOD,
        OP_LAND
    } t_op;

    typedef struct packed {
        logic load_in;
        logic load_out;
        t_op  op;
    } t_dp_ctl;

    typedef struct packed {
        logic cmd_tick;
        logic cmd_setpos;
        logic tick_adv;
        logic next_jump;
        logic loop_more;
        logic mod_last;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [FRAME_W-1:0]  frame_bits;
        logic [DUR_W-1:0]    duration;
        logic [POS_IN_W-1:0] position;
        logic [REP_W-1:0]    repeat_limit_in;
    } t_in_item;

    typedef struct packed {
        logic [FRAME_W-1:0]  light_levels;
        logic [MASK_W-1:0]   light_mask;
        logic [POS_IN_W-1:0] current_position;
        logic [FRAME_W-1:0]  current_frame;
        logic                playing;
    } t_res_item;

endpackage

// File: design/lap_cmd_if.sv
interface lap_cmd_if;
    import lap_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [FRAME_W-1:0]  frame_bits;
    logic [DUR_W-1:0]    duration;
    logic [POS_IN_W-1:0] position;
    logic [REP_W-1:0]    repeat_limit_in;

    modport source (
        output valid, cmd, frame_bits, duration, position, repeat_limit_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_bits, duration, position, repeat_limit_in,
        output ready
    );
endinterface

// File: design/lap_res_if.sv
interface lap_res_if;
    import lap_pkg::*;

    logic                valid;
    logic                ready;
    logic [FRAME_W-1:0]  light_levels;
    logic [MASK_W-1:0]   light_mask;
    logic [POS_IN_W-1:0] current_position;
    logic [FRAME_W-1:0]  current_frame;
    logic                playing;

    modport source (
        output valid, light_levels, light_mask, current_position, current_frame, playing,
        input  ready
    );
    modport sink (
        input  valid, light_levels, light_mask, current_position, current_frame, playing,
        output ready
    );
endinterface

// File: design/lap_ctrl.sv
module lap_ctrl #(
    parameter int FRAME_DEPTH = lap_pkg::FRAME_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output lap_pkg::t_dp_ctl  o_ctl,
    input  lap_pkg::t_dp_stat i_st
);
    import lap_pkg::*;

    localparam bit POW2 = (FRAME_DEPTH & (FRAME_DEPTH - 1)) == 0;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_st.cmd_tick) begin
                    n_state = i_st.tick_adv ? S_NEXT : S_DONE;
                end else if (i_st.cmd_setpos && !POW2) begin
                    n_state = S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_NEXT: begin
                if (i_st.next_jump && i_st.loop_more) begin
                    n_state = POW2 ? S_LAND : S_MOD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MOD: begin
                if (i_st.mod_last) begin
                    n_state = i_st.cmd_tick ? S_LAND : S_DONE;
                end
            end
            S_LAND: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    n_state = i_in_valid ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == S_IDLE) || ((r_state == S_DONE) && i_st.out_free);
        o_ctl.load_in  = i_in_valid && o_in_ready;
        o_ctl.load_out = (r_state == S_DONE) && i_st.out_free;
        case (r_state)
            S_EXEC:  o_ctl.op = i_st.cmd_tick ? OP_TICK : OP_DIRECT;
            S_NEXT:  o_ctl.op = OP_NEXT;
            S_MOD:   o_ctl.op = OP_MOD;
            S_LAND:  o_ctl.op = OP_LAND;
            default: o_ctl.op = OP_NONE;
        endcase
    end

    a_accept_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_in |-> (r_state == S_IDLE) || (r_state == S_DONE))
        else $error("transaction accepted while an item is in work");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && !i_st.out_free |=> (r_state == S_DONE))
        else $error("result dropped while output register busy");

    a_mod_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) && i_st.mod_last && i_st.cmd_tick |=> (r_state == S_LAND))
        else $error("jump remainder did not land");
endmodule

// File: design/lap_datapath.sv
module lap_datapath #(
    parameter int FRAME_DEPTH = lap_pkg::FRAME_DEPTH_DEF,
    parameter int LIGHT_COUNT = lap_pkg::LIGHT_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lap_pkg::t_dp_ctl   i_ctl,
    output lap_pkg::t_dp_stat  o_st,
    input  lap_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output lap_pkg::t_res_item o_res
);
    import lap_pkg::*;

    localparam int PW   = $clog2(FRAME_DEPTH);
    localparam bit POW2 = (FRAME_DEPTH & (FRAME_DEPTH - 1)) == 0;

    localparam int RECIP_W  = POS_SRC_W + 1;
    localparam int PROD_W   = POS_SRC_W + RECIP_W;
    localparam int RECIP_SH = POS_SRC_W + PW;
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_SH) + 64'(FRAME_DEPTH) - 64'd1) / 64'(FRAME_DEPTH);

    logic [ENTRY_W-1:0] mem [FRAME_DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    t_in_item           r_item;
    logic [FRAME_W-1:0] r_shown,   n_shown;
    logic [FRAME_W-1:0] r_direct,  n_direct;
    logic [PW-1:0]      r_pos,     n_pos;
    logic [TICK_W-1:0]  r_ticks,   n_ticks;
    logic [REP_W-1:0]   r_limit,   n_limit;
    logic [REP_W-1:0]   r_loops,   n_loops;
    logic               r_running, n_running;
    logic [PHASE_W-1:0] r_phase,   n_phase;
    logic               r_out_valid;
    t_res_item          r_res;

    logic [POS_SRC_W-1:0] r_mod_div;
    logic [POS_SRC_W-1:0] r_mod_q;
    logic [MOD_CNT_W-1:0] r_mod_cnt;
    logic [PROD_W-1:0]    mod_prod;
    logic [POS_SRC_W-1:0] mod_qd;
    logic [POS_SRC_W-1:0] mod_rem;
    logic                 mod_load;
    logic [POS_SRC_W-1:0] mod_src;

    logic                 mem_we;
    logic [PW-1:0]        pos_inc;
    logic [POS_SRC_W-1:0] pos_set16;
    logic [POS_SRC_W-1:0] target16;
    logic [POS_SRC_W-1:0] pos_ext;
    logic [DUR_W-1:0]     rd_dur;
    logic [FRAME_W-1:0]   rd_frame;
    logic [TICK_W-1:0]    ticks_inc;
    logic [REP_W-1:0]     loops_inc;
    logic [MASK_W-1:0]    mask;
    logic [2:0]           lv;

    assign rd_dur    = r_rdata[ENTRY_W-1 -: DUR_W];
    assign rd_frame  = r_rdata[FRAME_W-1:0];
    assign target16  = r_rdata[TARGET_LSB +: POS_SRC_W];
    assign pos_set16 = POS_SRC_W'(r_item.position);
    assign pos_inc   = (r_pos == PW'(FRAME_DEPTH - 1)) ? '0 : r_pos + PW'(1);
    assign ticks_inc = r_ticks + TICK_W'(1);
    assign loops_inc = r_loops + REP_W'(1);
    assign pos_ext   = POS_SRC_W'(r_pos);

    assign mod_prod = PROD_W'(r_mod_div) * PROD_W'(RECIP_M);
    assign mod_qd   = POS_SRC_W'(32'(r_mod_q) * 32'(FRAME_DEPTH));
    assign mod_rem  = r_mod_div - mod_qd;

    always_comb begin
        o_st.cmd_tick   = r_item.cmd == CMD_ANIMTICK;
        o_st.cmd_setpos = r_item.cmd == CMD_SETPOS;
        o_st.tick_adv   = r_running && !(ticks_inc < rd_dur);
        o_st.next_jump  = rd_dur == '0;
        o_st.loop_more  = (loops_inc != r_limit) || (r_limit == '0);
        o_st.mod_last   = r_mod_cnt == MOD_CNT_W'(MOD_STEPS - 1);
        o_st.out_free   = !r_out_valid || i_res_ready;
    end

    always_comb begin
        n_shown   = r_shown;
        n_direct  = r_direct;
        n_pos     = r_pos;
        n_ticks   = r_ticks;
        n_limit   = r_limit;
        n_loops   = r_loops;
        n_running = r_running;
        n_phase   = r_phase;
        mem_we    = 1'b0;
        mod_load  = 1'b0;
        mod_src   = pos_set16;
        case (i_ctl.op)
            OP_DIRECT: begin
                case (r_item.cmd)
                    CMD_SETFRAME: begin
                        n_running = 1'b0;
                        n_direct  = r_item.frame_bits;
                        n_shown   = r_item.frame_bits;
                    end
                    CMD_SETPOS: begin
                        if (POW2) begin
                            n_pos = pos_set16[PW-1:0];
                        end else begin
                            mod_load = 1'b1;
                        end
                    end
                    CMD_WRITEFRAME: begin
                        mem_we = 1'b1;
                        n_pos  = pos_inc;
                    end
                    CMD_START: begin
                        n_loops   = '0;
                        n_limit   = r_item.repeat_limit_in;
                        n_running = 1'b1;
                        n_shown   = rd_frame;
                    end
                    CMD_PAUSE: begin
                        n_running = 1'b0;
                    end
                    CMD_RESET: begin
                        n_running = 1'b0;
                        n_pos     = '0;
                        n_ticks   = '0;
                        n_shown   = '0;
                    end
                    CMD_PWMTICK: begin
                        n_phase = (r_phase == PHASE_W'(PWM_MOD - 1)) ? '0 : r_phase + PHASE_W'(1);
                    end
                    CMD_GETFRAME, CMD_GETPOS, CMD_ANIMTICK: begin
                    end
                    default: begin
                    end
                endcase
            end
            OP_TICK: begin
                if (r_running) begin
                    n_ticks = ticks_inc;
                    if (o_st.tick_adv) begin
                        n_pos = pos_inc;
                    end
                end
            end
            OP_NEXT: begin
                if (!o_st.next_jump) begin
                    n_ticks = '0;
                    n_shown = rd_frame;
                end else begin
                    n_loops = loops_inc;
                    if (o_st.loop_more) begin
                        if (POW2) begin
                            n_pos = target16[PW-1:0];
                        end else begin
                            mod_load = 1'b1;
                            mod_src  = target16;
                        end
                    end else begin
                        n_running = 1'b0;
                        n_shown   = '0;
                    end
                end
            end
            OP_MOD: begin
                if (o_st.mod_last) begin
                    n_pos = mod_rem[PW-1:0];
                end
            end
            OP_LAND: begin
                n_ticks = '0;
                n_shown = rd_frame;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown     <= '0;
            r_direct    <= '0;
            r_pos       <= '0;
            r_ticks     <= '0;
            r_limit     <= '0;
            r_loops     <= '0;
            r_running   <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_shown   <= n_shown;
            r_direct  <= n_direct;
            r_pos     <= n_pos;
            r_ticks   <= n_ticks;
            r_limit   <= n_limit;
            r_loops   <= n_loops;
            r_running <= n_running;
            r_phase   <= n_phase;
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_pos] <= {r_item.duration, r_item.frame_bits};
        end
        r_rdata <= mem[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_item <= i_item;
        end
        if (mod_load) begin
            r_mod_div <= mod_src;
            r_mod_cnt <= '0;
        end else if (i_ctl.op == OP_MOD) begin
            r_mod_q   <= POS_SRC_W'(mod_prod >> RECIP_SH);
            r_mod_cnt <= r_mod_cnt + MOD_CNT_W'(1);
        end
    end

    always_comb begin
        mask = '0;
        lv   = '0;
        for (int i = 0; i < MAX_LIGHTS; i++) begin
            if (i < LIGHT_COUNT) begin
                lv = r_shown[(FRAME_W - LEVEL_BITS - LEVEL_BITS * i) +: LEVEL_BITS];
                mask[MASK_W - 1 - i] = LEVEL_SQ[lv] > r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_res.light_levels     <= r_shown;
            r_res.light_mask       <= mask;
            r_res.current_position <= pos_ext[POS_IN_W-1:0];
            r_res.current_frame    <= r_direct;
            r_res.playing          <= r_running;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    a_state_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_phase) < PWM_MOD) && (32'(r_pos) < FRAME_DEPTH))
        else $error("phase or position out of range");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_NEXT) && o_st.next_jump && !o_st.loop_more
        |=> !r_running && (r_shown == '0))
        else $error("repeat limit reached without stopping");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.op == OP_TICK) && !r_running |=> $stable(r_ticks) && $stable(r_pos))
        else $error("animation tick moved a paused player");
endmodule

// File: design/led_animation_player_top.sv
// Command-driven LED animation player: one transaction on i_cmd_ch produces exactly one
// result transaction on o_res_ch, carrying the shown levels, the pwm on-mask, the play
// position, the direct frame and the run flag as they stand after the command. Items are
// processed one at a time; a new command is taken in the same cycle the previous result
// enters the output register. An animation tick that moves to the next entry goes through
// S_EXEC and S_NEXT, and also S_LAND when that entry is a jump, because each store lookup
// waits on the single registered read port of the frame store. With a FRAME_DEPTH that
// is not a power of two, set position and jump targets are reduced by a two-step
// reciprocal multiply in S_MOD. Store entries read before they are written return
// undefined frames; there is no clearing pass after reset.
module led_animation_player_top #(
    parameter int FRAME_DEPTH = lap_pkg::FRAME_DEPTH_DEF,
    parameter int LIGHT_COUNT = lap_pkg::LIGHT_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lap_cmd_if.sink   i_cmd_ch,
    lap_res_if.source o_res_ch
);
    import lap_pkg::*;

    t_dp_ctl   ctl;
    t_dp_stat  st;
    t_in_item  item;
    t_res_item res;
    logic      in_ready;
    logic      res_valid;

    assign item.cmd             = i_cmd_ch.cmd;
    assign item.frame_bits      = i_cmd_ch.frame_bits;
    assign item.duration        = i_cmd_ch.duration;
    assign item.position        = i_cmd_ch.position;
    assign item.repeat_limit_in = i_cmd_ch.repeat_limit_in;
    assign i_cmd_ch.ready       = in_ready;

    assign o_res_ch.valid            = res_valid;
    assign o_res_ch.light_levels     = res.light_levels;
    assign o_res_ch.light_mask       = res.light_mask;
    assign o_res_ch.current_position = res.current_position;
    assign o_res_ch.current_frame    = res.current_frame;
    assign o_res_ch.playing          = res.playing;

    lap_ctrl #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd_ch.valid),
        .o_in_ready (in_ready),
        .o_ctl      (ctl),
        .i_st       (st)
    );

    lap_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH),
        .LIGHT_COUNT (LIGHT_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_st        (st),
        .i_item      (item),
        .o_res_valid (res_valid),
        .i_res_ready (o_res_ch.ready),
        .o_res       (res)
    );
endmodule

// File: bench/led_animation_player_top_tb.sv
module led_animation_player_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lap_pkg::*;

    localparam int DEPTH        = FRAME_DEPTH_DEF;
    localparam int LIGHTS       = LIGHT_COUNT_DEF;
    localparam int TARGET_CMDS  = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 16;

    class player_checker;
        logic [ENTRY_W-1:0] store [DEPTH];
        bit                 written [DEPTH];
        logic [FRAME_W-1:0] shown;
        logic [FRAME_W-1:0] direct;
        int                 play_pos;
        logic [TICK_W-1:0]  ticks;
        logic [REP_W-1:0]   limit;
        logic [REP_W-1:0]   loops;
        bit                 run;
        int                 phase;
        t_res_item          status_due[$];
        int                 mismatches;
        int                 orphans;
        int                 checked;
        int                 jumps;
        int                 ends;

        function new();
            foreach (written[k]) written[k] = 1'b0;
            shown      = '0;
            direct     = '0;
            play_pos   = 0;
            ticks      = '0;
            limit      = '0;
            loops      = '0;
            run        = 1'b0;
            phase      = 0;
            mismatches = 0;
            orphans    = 0;
            checked    = 0;
            jumps      = 0;
            ends       = 0;
        endfunction

        function logic [DUR_W-1:0] dur_at(int p);
            return store[p][ENTRY_W-1:FRAME_W];
        endfunction

        function bit reads_unwritten(t_in_item it);
            int np;
            int tg;
            logic [TICK_W-1:0] t;
            case (it.cmd)
                CMD_START: return !written[play_pos];
                CMD_ANIMTICK: begin
                    if (!run) return 1'b0;
                    if (!written[play_pos]) return 1'b1;
                    t = ticks + 1'b1;
                    if (t < dur_at(play_pos)) return 1'b0;
                    np = (play_pos + 1) % DEPTH;
                    if (!written[np]) return 1'b1;
                    if (dur_at(np) != '0) return 1'b0;
                    if (REP_W'(loops + 1'b1) == limit && limit != '0) return 1'b0;
                    tg = store[np][FRAME_W-1:TARGET_LSB] % DEPTH;
                    return !written[tg];
                end
                default: return 1'b0;
            endcase
        endfunction

        function logic [MASK_W-1:0] on_mask();
            logic [MASK_W-1:0] m;
            int lv;
            m = '0;
            for (int i = 0; i < LIGHTS && i < MAX_LIGHTS; i++) begin
                lv = shown[FRAME_W-LEVEL_BITS-LEVEL_BITS*i +: LEVEL_BITS];
                if (lv * lv > phase) m[MASK_W-1-i] = 1'b1;
            end
            return m;
        endfunction

        function t_res_item play_step(t_in_item it);
            t_res_item r;
            case (it.cmd)
                CMD_SETFRAME: begin
                    run    = 1'b0;
                    direct = it.frame_bits;
                    shown  = it.frame_bits;
                end
                CMD_SETPOS: play_pos = it.position % DEPTH;
                CMD_WRITEFRAME: begin
                    store[play_pos]   = {it.duration, it.frame_bits};
                    written[play_pos] = 1'b1;
                    play_pos          = (play_pos + 1) % DEPTH;
                end
                CMD_START: begin
                    loops = '0;
                    limit = it.repeat_limit_in;
                    run   = 1'b1;
                    shown = store[play_pos][FRAME_W-1:0];
                end
                CMD_PAUSE: run = 1'b0;
                CMD_RESET: begin
                    run      = 1'b0;
                    play_pos = 0;
                    ticks    = '0;
                    shown    = '0;
                end
                CMD_ANIMTICK: begin
                    if (run) begin
                        ticks = ticks + 1'b1;
                        if (ticks >= dur_at(play_pos)) begin
                            play_pos = (play_pos + 1) % DEPTH;
                            if (dur_at(play_pos) == '0) begin
                                loops = loops + 1'b1;
                                if (loops != limit || limit == '0) begin
                                    play_pos = store[play_pos][FRAME_W-1:TARGET_LSB] % DEPTH;
                                    jumps++;
                                end else begin
                                    run   = 1'b0;
                                    shown = '0;
                                    ends++;
                                end
                            end
                            if (run) begin
                                ticks = '0;
                                shown = store[play_pos][FRAME_W-1:0];
                            end
                        end
                    end
                end
                CMD_PWMTICK: phase = (phase + 1) % PWM_MOD;
                default: ;
            endcase
            r.light_levels     = shown;
            r.light_mask       = on_mask();
            r.current_position = POS_IN_W'(play_pos);
            r.current_frame    = direct;
            r.playing          = run;
            return r;
        endfunction

        function void note_command(t_in_item it);
            status_due.push_back(play_step(it));
        endfunction

        function void match(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches + orphans <= 10)
                    $display("status %0d: %s expected %h, got %h", checked, what, want, got);
            end
        endfunction

        function void check_status(t_res_item got);
            t_res_item want;
            if (status_due.size() == 0) begin
                orphans++;
                if (mismatches + orphans <= 10)
                    $display("status with no command waiting: %p", got);
                return;
            end
            want = status_due.pop_front();
            match("light_levels", 64'(want.light_levels), 64'(got.light_levels));
            match("light_mask", 64'(want.light_mask), 64'(got.light_mask));
            match("current_position", 64'(want.current_position),
                  64'(got.current_position));
            match("current_frame", 64'(want.current_frame), 64'(got.current_frame));
            match("playing", 64'(want.playing), 64'(got.playing));
            checked++;
        endfunction

        function int failures();
            return mismatches + orphans;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lap_cmd_if cmd_ch ();
    lap_res_if res_ch ();

    led_animation_player_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch)
    );

    player_checker board = new();

    int useful_cmds = 0;
    int ignored_cmds = 0;
    int burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_in_item random_item(logic [CMD_W-1:0] c);
        t_in_item it;
        it.cmd             = c;
        it.frame_bits      = {16'($urandom()), 32'($urandom())};
        it.duration        = 16'($urandom());
        it.position        = 8'($urandom());
        it.repeat_limit_in = 8'($urandom());
        return it;
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return DUR_W'($urandom_range(1, 3));
        if (r < 85) return DUR_W'($urandom_range(4, 20));
        if (r < 95) return DUR_W'($urandom_range(1, 65535));
        return '1;
    endfunction

    function automatic logic [REP_W-1:0] pick_repeat();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return REP_W'($urandom_range(1, 3));
        if (r < 75) return '0;
        if (r < 90) return REP_W'($urandom_range(4, 20));
        return REP_W'($urandom_range(1, 255));
    endfunction

    task automatic send_command(input t_in_item it);
        cmd_ch.valid           <= 1'b1;
        cmd_ch.cmd             <= it.cmd;
        cmd_ch.frame_bits      <= it.frame_bits;
        cmd_ch.duration        <= it.duration;
        cmd_ch.position        <= it.position;
        cmd_ch.repeat_limit_in <= it.repeat_limit_in;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        board.note_command(it);
        if (it.cmd > CMD_PWMTICK) ignored_cmds++;
        else useful_cmds++;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic issue(input t_in_item it);
        if (board.reads_unwritten(it)) begin
            it = random_item(CMD_WRITEFRAME);
            it.duration = pick_duration();
        end
        send_command(it);
    endtask

    task automatic issue_cmd(input logic [CMD_W-1:0] c);
        issue(random_item(c));
    endtask

    task automatic run_directed();
        t_in_item it;
        it = random_item(CMD_SETFRAME);
        it.frame_bits = '1;
        issue(it);
        issue_cmd(CMD_GETFRAME);
        issue_cmd(CMD_PWMTICK);
        it = random_item(CMD_SETFRAME);
        it.frame_bits = '0;
        issue(it);
        it = random_item(CMD_SETPOS);
        it.position = '1;
        issue(it);
        it = random_item(CMD_WRITEFRAME);
        it.duration = 16'd1;
        issue(it);
        it = random_item(CMD_WRITEFRAME);
        it.duration = 16'd2;
        issue(it);
        it = random_item(CMD_WRITEFRAME);
        it.duration = '0;
        it.frame_bits[FRAME_W-1:TARGET_LSB] = 16'h01FF;
        issue(it);
        issue_cmd(CMD_GETPOS);
        it = '1;
        issue(it);
        issue_cmd(CMD_ANIMTICK);
        it = random_item(CMD_SETPOS);
        it.position = '1;
        issue(it);
        it = random_item(CMD_START);
        it.repeat_limit_in = 8'd2;
        issue(it);
        repeat (7) issue_cmd(CMD_ANIMTICK);
        issue_cmd(CMD_PAUSE);
        issue_cmd(CMD_RESET);
        it = random_item(CMD_START);
        it.repeat_limit_in = '1;
        issue(it);
        issue_cmd(CMD_ANIMTICK);
        issue_cmd(CMD_PAUSE);
    endtask

    task automatic run_program();
        t_in_item it;
        int base;
        int n;
        int steps;
        int r;
        base = $urandom_range(0, DEPTH - 1);
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 3) == 0) issue_cmd(CMD_RESET);
        it = random_item(CMD_SETPOS);
        it.position = POS_IN_W'(base);
        issue(it);
        for (int k = 0; k < n; k++) begin
            it = random_item(CMD_WRITEFRAME);
            it.duration = pick_duration();
            issue(it);
        end
        it = random_item(CMD_WRITEFRAME);
        it.duration = '0;
        it.frame_bits[TARGET_LSB +: 8] = 8'(base + $urandom_range(0, n - 1));
        issue(it);
        it = random_item(CMD_SETPOS);
        it.position = POS_IN_W'(base + $urandom_range(0, n));
        issue(it);
        it = random_item(CMD_START);
        it.repeat_limit_in = pick_repeat();
        issue(it);
        steps = $urandom_range(8, 40);
        for (int k = 0; k < steps; k++) begin
            r = $urandom_range(0, 99);
            if (r < 65) issue_cmd(CMD_ANIMTICK);
            else if (r < 85) issue_cmd(CMD_PWMTICK);
            else if (r < 90) issue_cmd(CMD_PAUSE);
            else if (r < 94) begin
                it = random_item(CMD_START);
                it.repeat_limit_in = pick_repeat();
                issue(it);
            end else issue_cmd(CMD_W'($urandom_range(0, 15)));
        end
    endtask

    initial begin
        int k;
        int hold_left;
        int mode;
        int mode_left;
        k = 0;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            k++;
            if (k == HOLD_START) hold_left = HOLD_CYCLES;
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= 1'($urandom_range(0, 1));
                    2: res_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: res_ch.ready <= (k % 7 != 0);
                endcase
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_res_item seen;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen.light_levels     = res_ch.light_levels;
            seen.light_mask       = res_ch.light_mask;
            seen.current_position = res_ch.current_position;
            seen.current_frame    = res_ch.current_frame;
            seen.playing          = res_ch.playing;
            board.check_status(seen);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d statuses outstanding",
                 CYCLE_LIMIT, board.status_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n                <= 1'b0;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.cmd             <= '0;
        cmd_ch.frame_bits      <= '0;
        cmd_ch.duration        <= '0;
        cmd_ch.position        <= '0;
        cmd_ch.repeat_limit_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        while (useful_cmds < TARGET_CMDS) begin
            if ($urandom_range(0, 9) < 8) run_program();
            else issue_cmd(CMD_W'($urandom_range(0, 15)));
        end
        cmd_ch.valid <= 1'b0;
        while (board.status_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d commands sent (%0d ignored codes), %0d statuses checked",
                 useful_cmds + ignored_cmds, ignored_cmds, board.checked);
        $display("%0d loop jumps taken, %0d playbacks ran out, %0d mismatches",
                 board.jumps, board.ends, board.failures());
        if (board.failures() == 0 && board.status_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
